// ===== src/cke_pkg.sv =====
// Shared constants and helper functions for the Kermit CRC async frame encoder.
// No dependencies; imported by the encoder top level and its checker.
package cke_pkg;

   localparam int unsigned        ByteW      = 8;
   localparam int unsigned        CrcW       = 16;
   localparam int unsigned        BufW       = 56;   // seven output bytes
   localparam int unsigned        ResW       = 7;    // leftover bits between items
   localparam logic [CrcW-1:0]    KermitPoly = 16'h8408;
   localparam logic [CrcW-1:0]    KermitInit = 16'h0000;
   localparam logic [ByteW-1:0]   CloseByte  = 8'hFF;

   // One byte of the reflected CRC-16 Kermit update.
   function automatic logic [CrcW-1:0] kermit_update(input logic [CrcW-1:0] crc,
                                                     input logic [ByteW-1:0] data);
      logic [CrcW-1:0] c;
      c = crc ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ KermitPoly;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   // Bit order swap: LSB-first wire order into an MSB-first packed vector.
   function automatic logic [ByteW-1:0] bit_reverse8(input logic [ByteW-1:0] v);
      logic [ByteW-1:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = v[7-i];
      end
      return r;
   endfunction

endpackage

// ===== src/crc_kermit_async_frame_encoder_unit.sv =====
// Top level of the Kermit CRC async frame encoder: input stage, bit packer,
// output byte buffer. Depends on cke_pkg.
//
// Frame bytes come in on req_*; each is framed as a 0 start bit (first byte)
// or three 1 stop bits plus a 0 start bit (later bytes), followed by its eight
// bits LSB first, and the bit stream is packed MSB first into rsp_out_byte.
// With csr_write_data set (reset value 1), the final data byte is followed by
// the CRC-16 Kermit low and high bytes; the frame is then padded with 1s to a
// byte boundary and closed by a 0xFF byte flagged by rsp_frame_end.
// rsp_run_last marks the last output byte caused by an input transfer.
// An item is held in the input register and is then turned into all its output
// bytes in a single pass; the output buffer hands out one byte per cycle while
// rsp_stall is low, and the next item moves in as the previous item's last byte
// is taken, so a waiting input transfer is held until the bytes of the previous
// item (1 or 2 for a data byte, up to 7 for a final byte with CRC) are out. The
// output port's byte rate thus sets the input rate.
module crc_kermit_async_frame_encoder_unit
   import cke_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   // configuration
   input  logic             csr_write_enable,
   input  logic             csr_write_data,
   // input channel
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [ByteW-1:0] req_data_byte,
   input  logic             req_last_byte,
   // result channel
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [ByteW-1:0] rsp_out_byte,
   output logic             rsp_run_last,
   output logic             rsp_frame_end
);

   // configuration register
   logic             append_ff;

   // input stage
   logic             item_valid_ff;
   logic [ByteW-1:0] item_data_ff;
   logic             item_last_ff;

   // frame state
   logic [CrcW-1:0]  crc_ff, crc_in;
   logic [ResW-1:0]  residue_ff, residue_in;
   logic [2:0]       res_cnt_ff, res_cnt_in;
   logic             first_ff, first_in;

   // output byte buffer
   logic [BufW-1:0]  buf_ff, buf_in;
   logic [2:0]       cnt_ff, cnt_in;
   logic             end_ff, end_in;

   logic             move;
   logic             take;

   // packer signals
   logic [CrcW-1:0]  new_crc;
   logic [BufW-1:0]  res_left;
   logic [BufW-1:0]  data_chunk;
   logic [BufW-1:0]  crc_chunk;
   logic [BufW-1:0]  pad_fill;
   logic [BufW-1:0]  stream;
   logic [BufW-1:0]  shifted;
   logic [3:0]       len_d;
   logic [4:0]       crc_pos;
   logic [5:0]       total;
   logic [5:0]       total_up;
   logic [2:0]       nbytes;
   logic             add_crc;

   // handshake
   assign take      = rsp_valid && !rsp_stall;
   assign move      = item_valid_ff && ((cnt_ff == 3'd0) || ((cnt_ff == 3'd1) && !rsp_stall));
   assign req_stall = item_valid_ff && !move;

   // configuration write
   always_ff @(posedge clock) begin
      if (reset) begin
         append_ff <= 1'b1;
      end else if (csr_write_enable) begin
         append_ff <= csr_write_data;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_data_ff <= req_data_byte;
         item_last_ff <= req_last_byte;
      end
   end

   // bit packer: leftover bits, data byte, optional CRC bytes, then 1s padding
   always_comb begin
      new_crc    = kermit_update(crc_ff, item_data_ff);
      add_crc    = item_last_ff && append_ff;
      res_left   = {residue_ff, 49'd0} << (3'd7 - res_cnt_ff);
      if (first_ff) begin
         data_chunk = {1'b0, bit_reverse8(item_data_ff), 47'd0};
         len_d      = 4'd9;
      end else begin
         data_chunk = {4'b1110, bit_reverse8(item_data_ff), 44'd0};
         len_d      = 4'd12;
      end
      crc_chunk  = {4'b1110, bit_reverse8(new_crc[7:0]),
                    4'b1110, bit_reverse8(new_crc[15:8]), 32'd0};
      crc_pos    = {2'b00, res_cnt_ff} + {1'b0, len_d};
      total      = {1'b0, crc_pos} + (add_crc ? 6'd24 : 6'd0);
      pad_fill   = item_last_ff ? ({BufW{1'b1}} >> total) : '0;
      stream     = res_left | (data_chunk >> res_cnt_ff)
                 | (add_crc ? (crc_chunk >> crc_pos) : '0) | pad_fill;
      total_up   = total + 6'd7;
      // final byte: round up, plus the closing 0xFF (all-ones fill)
      nbytes     = item_last_ff ? (total_up[5:3] + 3'd1) : total[5:3];
      shifted    = stream << {total[5:3], 3'b000};
      residue_in = shifted[BufW-1 -: ResW] >> (3'd7 - total[2:0]);
      if (item_last_ff) begin
         crc_in     = KermitInit;
         res_cnt_in = 3'd0;
         first_in   = 1'b1;
      end else begin
         crc_in     = new_crc;
         res_cnt_in = total[2:0];
         first_in   = 1'b0;
      end
   end

   // frame state update on each item moved into the buffer
   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff     <= KermitInit;
         residue_ff <= '0;
         res_cnt_ff <= 3'd0;
         first_ff   <= 1'b1;
      end else if (move) begin
         crc_ff     <= crc_in;
         residue_ff <= item_last_ff ? '0 : residue_in;
         res_cnt_ff <= res_cnt_in;
         first_ff   <= first_in;
      end
   end

   // output buffer next value
   always_comb begin
      buf_in = buf_ff;
      cnt_in = cnt_ff;
      end_in = end_ff;
      if (move) begin
         buf_in = stream;
         cnt_in = nbytes;
         end_in = item_last_ff;
      end else if (take) begin
         buf_in = buf_ff << ByteW;
         cnt_in = cnt_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 3'd0;
         end_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         end_ff <= end_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

   // result port
   assign rsp_valid     = (cnt_ff != 3'd0);
   assign rsp_out_byte  = buf_ff[BufW-1 -: ByteW];
   assign rsp_run_last  = (cnt_ff == 3'd1);
   assign rsp_frame_end = end_ff && (cnt_ff == 3'd1);

endmodule

// ===== src/cke_checker.sv =====
// Port-level checker for the Kermit CRC async frame encoder, bound to the top.
// Depends on cke_pkg.
module cke_checker
   import cke_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [ByteW-1:0] rsp_out_byte,
   input logic             rsp_run_last,
   input logic             rsp_frame_end
);

   // the closing byte is always the last one of its input's run
   a_end_is_run_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_run_last)
      else $error("frame_end without run_last");

   // the closing byte carries all ones
   a_end_byte_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> (rsp_out_byte == CloseByte))
      else $error("frame_end byte is not 0xFF");

   // a stalled result stays put
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
                                 && $stable(rsp_run_last) && $stable(rsp_frame_end))
      else $error("stalled result changed");

endmodule

bind crc_kermit_async_frame_encoder_unit cke_checker u_cke_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_out_byte (rsp_out_byte),
   .rsp_run_last (rsp_run_last),
   .rsp_frame_end(rsp_frame_end)
);

// ===== tb/crc_kermit_async_frame_encoder_unit_tb.sv =====
// Testbench for the Kermit CRC async frame encoder: directed and random frames
// checked byte by byte against a local bit-level encoding predictor.
// Depends on cke_pkg and crc_kermit_async_frame_encoder_unit.
`timescale 1ns / 1ps

module crc_kermit_async_frame_encoder_unit_tb
   import cke_pkg::*;
;

   localparam int unsigned CycleLimit  = 200000;
   localparam int unsigned SettleTicks = 16;    // input register plus packing pass, with margin
   localparam int unsigned IdlePct     = 28;

   typedef struct packed {
      logic [ByteW-1:0] out_byte;
      logic             run_last;
      logic             frame_end;
   } enc_byte_type;

   logic             clock            = 1'b0;
   logic             reset            = 1'b1;
   logic             csr_write_enable = 1'b0;
   logic             csr_write_data   = 1'b0;
   logic             req_valid        = 1'b0;
   logic             req_stall;
   logic [ByteW-1:0] req_data_byte    = '0;
   logic             req_last_byte    = 1'b0;
   logic             rsp_valid;
   logic             rsp_stall        = 1'b0;
   logic [ByteW-1:0] rsp_out_byte;
   logic             rsp_run_last;
   logic             rsp_frame_end;

   // encoder state mirror
   logic [CrcW-1:0]  running_crc    = KermitInit;
   logic [ResW-1:0]  pend_bits      = '0;
   logic [2:0]       pend_cnt       = '0;
   logic             at_frame_start = 1'b1;
   logic             append_en      = 1'b1;

   enc_byte_type     encoded_q[$];
   int unsigned      errors      = 0;
   int unsigned      cycle_count = 0;
   bit               steady      = 1'b0;   // no idling on either side while set

   crc_kermit_async_frame_encoder_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_run_last     (rsp_run_last),
      .rsp_frame_end    (rsp_frame_end)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------
   // Encoding predictor
   // ---------------------------------------------------------------

   // Reflected CRC-16, one data bit at a time.
   function automatic logic [CrcW-1:0] kermit_next(input logic [CrcW-1:0] crc,
                                                   input logic [ByteW-1:0] v);
      logic [CrcW-1:0] r;
      logic            fb;
      r = crc;
      for (int i = 0; i < ByteW; i++) begin
         fb = r[0] ^ v[i];
         r  = r >> 1;
         if (fb) begin
            r = r ^ KermitPoly;
         end
      end
      return r;
   endfunction

   // Append one wire bit; every eighth bit completes an output byte.
   function automatic void shift_in_bit(input logic b);
      logic [ByteW-1:0] assembled;
      assembled = {pend_bits, b};
      if (pend_cnt == 3'd7) begin
         encoded_q.push_back(enc_byte_type'{assembled, 1'b0, 1'b0});
         pend_bits = '0;
         pend_cnt  = '0;
      end else begin
         pend_bits = assembled[ResW-1:0];
         pend_cnt  = pend_cnt + 3'd1;
      end
   endfunction

   // Stop bits (except at frame start), start bit, then data LSB first.
   function automatic void shift_in_char(input logic [ByteW-1:0] v);
      if (!at_frame_start) begin
         repeat (3) shift_in_bit(1'b1);
      end
      shift_in_bit(1'b0);
      for (int i = 0; i < ByteW; i++) begin
         shift_in_bit(v[i]);
      end
      at_frame_start = 1'b0;
   endfunction

   // Expected output bytes for one input transfer.
   function automatic void predict_encoding(input logic [ByteW-1:0] d, input logic last);
      int unsigned  first_new;
      enc_byte_type tail;
      first_new   = encoded_q.size();
      running_crc = kermit_next(running_crc, d);
      shift_in_char(d);
      if (last) begin
         if (append_en) begin
            shift_in_char(running_crc[7:0]);
            shift_in_char(running_crc[15:8]);
         end
         while (pend_cnt != 3'd0) begin
            shift_in_bit(1'b1);
         end
         encoded_q.push_back(enc_byte_type'{CloseByte, 1'b0, 1'b1});
         running_crc    = KermitInit;
         pend_bits      = '0;
         pend_cnt       = '0;
         at_frame_start = 1'b1;
      end
      if (encoded_q.size() > first_new) begin
         tail          = encoded_q.pop_back();
         tail.run_last = 1'b1;
         encoded_q.push_back(tail);
      end
   endfunction

   // ---------------------------------------------------------------
   // Output side: random stall and result check
   // ---------------------------------------------------------------

   always @(negedge clock) begin
      rsp_stall <= steady ? 1'b0 : ($urandom_range(99) < IdlePct);
   end

   always @(posedge clock) begin
      enc_byte_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (encoded_q.size() == 0) begin
            $error("unexpected output byte %02h", rsp_out_byte);
            errors++;
         end else begin
            want = encoded_q.pop_front();
            if (rsp_out_byte !== want.out_byte) begin
               $error("out_byte: expected %02h, got %02h", want.out_byte, rsp_out_byte);
               errors++;
            end
            if (rsp_run_last !== want.run_last) begin
               $error("run_last: expected %0b, got %0b", want.run_last, rsp_run_last);
               errors++;
            end
            if (rsp_frame_end !== want.frame_end) begin
               $error("frame_end: expected %0b, got %0b", want.frame_end, rsp_frame_end);
               errors++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("crc_kermit_async_frame_encoder_unit_tb: FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Input side
   // ---------------------------------------------------------------

   // Entered and left at a falling edge; valid stays high on return so a
   // following transfer can go out back to back.
   task automatic send_byte(input logic [ByteW-1:0] d, input logic last);
      while (!steady && ($urandom_range(99) < IdlePct)) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= d;
      req_last_byte <= last;
      predict_encoding(d, last);
      do begin
         @(posedge clock);
      end while (req_stall);
      @(negedge clock);
   endtask

   // Drop valid, drain all expected bytes, let the pipeline settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (encoded_q.size() != 0) begin
         @(negedge clock);
      end
      repeat (SettleTicks) @(negedge clock);
   endtask

   task automatic set_append_crc(input logic v);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      append_en         = v;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // One-byte frames with CRC at reset setting, data extremes.
   task automatic test_single_byte_frames();
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h80, 1'b1);
      send_byte(8'h01, 1'b1);
   endtask

   // Standard check string, CRC of "123456789" is 0x2189.
   task automatic test_check_string();
      for (int i = 0; i < 9; i++) begin
         send_byte(8'h31 + ByteW'(i), i == 8);
      end
   endtask

   task automatic test_crc_disabled();
      set_append_crc(1'b0);
      send_byte(8'hA5, 1'b1);
      send_byte(8'h5A, 1'b0);
      send_byte(8'hC3, 1'b1);
   endtask

   // Setting changed inside an open frame applies to its final byte.
   task automatic test_config_mid_frame();
      set_append_crc(1'b1);
      send_byte(8'h12, 1'b0);
      send_byte(8'h34, 1'b0);
      set_append_crc(1'b0);
      send_byte(8'h56, 1'b1);
      send_byte(8'h78, 1'b0);
      set_append_crc(1'b1);
      set_append_crc(1'b1);
      send_byte(8'h9A, 1'b1);
   endtask

   // Random frames, mostly short, now and then a long one.
   task automatic test_random_frames(input int unsigned n_items, input bit flip_cfg);
      int unsigned sent;
      int unsigned len;
      sent = 0;
      while (sent < n_items) begin
         if (flip_cfg) begin
            set_append_crc(1'($urandom_range(1)));
         end
         len = ($urandom_range(9) == 0) ? $urandom_range(16, 8) : $urandom_range(6, 1);
         for (int unsigned i = 0; i < len; i++) begin
            send_byte(ByteW'($urandom_range(255)), i == len - 1);
         end
         sent += len;
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_single_byte_frames();
      test_check_string();
      test_crc_disabled();
      test_config_mid_frame();

      set_append_crc(1'b1);
      test_random_frames(40, 1'b0);
      set_append_crc(1'b0);
      test_random_frames(30, 1'b0);

      // stretch with no idling on either side
      set_append_crc(1'b1);
      steady = 1'b1;
      test_random_frames(25, 1'b0);
      wait_idle();
      steady = 1'b0;

      test_random_frames(30, 1'b1);

      wait_idle();
      if (errors == 0) begin
         $display("crc_kermit_async_frame_encoder_unit_tb: PASS");
      end else begin
         $display("crc_kermit_async_frame_encoder_unit_tb: FAIL");
      end
      $finish;
   end

endmodule
